// File: hw/rtl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types for the two-digit display setpoint controller
// Word formats of the input and result channels, the configuration set and
// the register indexes of the configuration port.
// ----------------------------------------------------------------------------
package dsc_pkg;

  typedef struct packed {
    logic       power_on;
    logic [7:0] temperature;
    logic       enter_setting;
    logic       up_press;
    logic       down_press;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_enable;
    logic [6:0] segments;
    logic [7:0] setpoint_now;
    logic       setpoint_changed;
    logic       in_setting;
  } out_item_t;

  typedef struct packed {
    logic [7:0] min_setpoint;
    logic [7:0] max_setpoint;
    logic [7:0] initial_setpoint;
    logic [7:0] blink_ticks;
    logic [3:0] blink_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_MIN_SP   = 3'd0,
    CFG_MAX_SP   = 3'd1,
    CFG_INIT_SP  = 3'd2,
    CFG_BLINK_TK = 3'd3,
    CFG_BLINK_LM = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] RstMinSetpoint  = 8'd35;
  localparam logic [7:0] RstMaxSetpoint  = 8'd75;
  localparam logic [7:0] RstInitSetpoint = 8'd60;
  localparam logic [7:0] RstBlinkTicks   = 8'd25;
  localparam logic [3:0] RstBlinkLimit   = 4'd5;

endpackage

// File: hw/rtl/two_digit_display_setpoint_ctrl.sv
// ----------------------------------------------------------------------------
// two_digit_display_setpoint_ctrl: multiplexed two-digit display driver
// Drives a two-digit seven-segment display from temperature ticks and runs
// the setpoint adjust mode with its blink timing.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_word_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_word_o (out_item_t)
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Each tick word is held in the input register and its result is loaded
// into the output register when it moves on; one word is taken every
// cycle while the output drains.
// Reset loads the default configuration and the initial setpoint.
// A stall on the output holds the result and, once the input register is
// also full, raises in_stall_o in the same cycle.
// ----------------------------------------------------------------------------
module two_digit_display_setpoint_ctrl
  import dsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_word_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  cfg_t      cfg_q;
  logic      advance;
  logic      in_take;
  logic      sp_load;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign sp_load    = cfg_we_i & (cfg_idx_i == CFG_INIT_SP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_setpoint     <= RstMinSetpoint;
      cfg_q.max_setpoint     <= RstMaxSetpoint;
      cfg_q.initial_setpoint <= RstInitSetpoint;
      cfg_q.blink_ticks      <= RstBlinkTicks;
      cfg_q.blink_limit      <= RstBlinkLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_SP:   cfg_q.min_setpoint     <= cfg_wdata_i;
        CFG_MAX_SP:   cfg_q.max_setpoint     <= cfg_wdata_i;
        CFG_INIT_SP:  cfg_q.initial_setpoint <= cfg_wdata_i;
        CFG_BLINK_TK: cfg_q.blink_ticks      <= cfg_wdata_i;
        CFG_BLINK_LM: cfg_q.blink_limit      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  dsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .cfg_i         (cfg_q),
    .sp_load_i     (sp_load),
    .sp_load_val_i (cfg_wdata_i),
    .result_o      (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hw/rtl/dsc_seg_decode.sv
// ----------------------------------------------------------------------------
// dsc_seg_decode: digit select and seven-segment decode
// Picks the tens or units digit of an 8-bit value and decodes it to gfedcba;
// digits above nine decode to all segments off.
// ----------------------------------------------------------------------------
module dsc_seg_decode (
  input  logic [7:0] value_i,
  input  logic       tens_i,
  output logic [6:0] seg_o
);

  logic [15:0] prod;
  logic [4:0]  tens;
  logic [7:0]  tens_x10;
  logic [7:0]  units;
  logic [4:0]  digit;

  function automatic logic [6:0] seg_of(input logic [4:0] d);
    logic [6:0] s;
    case (d)
      5'd0:    s = 7'h3F;
      5'd1:    s = 7'h06;
      5'd2:    s = 7'h5B;
      5'd3:    s = 7'h4F;
      5'd4:    s = 7'h66;
      5'd5:    s = 7'h6D;
      5'd6:    s = 7'h7D;
      5'd7:    s = 7'h07;
      5'd8:    s = 7'h7F;
      5'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Multiply by 205/2048 gives the exact quotient by ten for 8-bit values.
  assign prod     = 16'(value_i) * 16'd205;
  assign tens     = prod[15:11];
  assign tens_x10 = {tens[4:0], 3'b000} + {2'b00, tens[4:0], 1'b0};
  assign units    = value_i - tens_x10;
  assign digit    = tens_i ? tens : units[4:0];
  assign seg_o    = seg_of(digit);

endmodule

// File: hw/rtl/dsc_ctrl.sv
// ----------------------------------------------------------------------------
// dsc_ctrl: mode, setpoint and blink control
// Holds the controller state and works out one tick from the registered input
// word; state and result advance on step_i, but an sp_load_i write wins.
// ----------------------------------------------------------------------------
module dsc_ctrl
  import dsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  input  logic      sp_load_i,
  input  logic [7:0] sp_load_val_i,
  output out_item_t result_o
);

  localparam logic [1:0] DigitBlank = 2'b00;
  localparam logic [1:0] DigitTens  = 2'b01;
  localparam logic [1:0] DigitUnits = 2'b10;

  logic [7:0] sp_q, sp_d;
  logic       mode_q, mode_d;
  logic       tens_q, tens_d;
  logic       hold_q, hold_d;
  logic       bon_q, bon_d;
  logic [7:0] tc_q, tc_d;
  logic [3:0] bc_q, bc_d;
  logic [6:0] seg_q, seg_d;

  logic       changed;
  logic       show_en;
  logic [7:0] show_val;
  logic [6:0] seg_new;
  logic [8:0] sp_up;

  assign sp_up = {1'b0, sp_q} + 9'd5;

  always_comb begin
    mode_d   = mode_q | item_i.enter_setting;
    hold_d   = hold_q;
    bon_d    = bon_q;
    tc_d     = tc_q;
    bc_d     = bc_q;
    sp_d     = sp_q;
    changed  = 1'b0;
    show_en  = 1'b0;
    show_val = sp_q;
    if (!item_i.power_on) begin
      mode_d = 1'b0;
    end else if (!mode_d) begin
      if ((item_i.temperature == sp_q) || hold_q) begin
        hold_d  = 1'b1;
        show_en = 1'b1;
      end else begin
        show_en  = 1'b1;
        show_val = item_i.temperature;
      end
    end else begin
      hold_d = 1'b0;
      // Any up press, or a down press that moves the setpoint, restarts the blink.
      if (item_i.up_press) begin
        if (sp_q < cfg_i.max_setpoint) begin
          sp_d    = sp_up[8] ? 8'hFF : sp_up[7:0];
          changed = 1'b1;
        end else begin
          sp_d = cfg_i.max_setpoint;
        end
        bon_d = 1'b0;
        tc_d  = '0;
        bc_d  = '0;
      end else if (item_i.down_press && (sp_q > cfg_i.min_setpoint)) begin
        sp_d    = (sp_q >= 8'd5) ? sp_q - 8'd5 : 8'd0;
        changed = 1'b1;
        bon_d   = 1'b0;
        tc_d    = '0;
        bc_d    = '0;
      end
      if (!bon_d) begin
        tc_d = tc_d + 8'd1;
        if (tc_d == cfg_i.blink_ticks) begin
          bon_d = 1'b1;
          tc_d  = '0;
          bc_d  = bc_d + 4'd1;
        end
      end else begin
        if (bc_d == cfg_i.blink_limit) begin
          mode_d = 1'b0;
          bc_d   = '0;
        end
        show_en  = 1'b1;
        show_val = sp_d;
        tc_d     = tc_d + 8'd1;
        if (tc_d == cfg_i.blink_ticks) begin
          bon_d = 1'b0;
          tc_d  = '0;
        end
      end
    end
  end

  dsc_seg_decode u_seg (
    .value_i (show_val),
    .tens_i  (tens_q),
    .seg_o   (seg_new)
  );

  assign seg_d  = show_en ? seg_new : seg_q;
  assign tens_d = show_en ? ~tens_q : tens_q;

  always_comb begin
    result_o.digit_enable     = show_en ? (tens_q ? DigitTens : DigitUnits) : DigitBlank;
    result_o.segments         = seg_d;
    result_o.setpoint_now     = sp_d;
    result_o.setpoint_changed = changed;
    result_o.in_setting       = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= RstInitSetpoint;
      mode_q <= 1'b0;
      tens_q <= 1'b1;
      hold_q <= 1'b0;
      bon_q  <= 1'b0;
      tc_q   <= '0;
      bc_q   <= '0;
      seg_q  <= '0;
    end else if (sp_load_i) begin
      sp_q <= sp_load_val_i;
    end else if (step_i) begin
      sp_q   <= sp_d;
      mode_q <= mode_d;
      tens_q <= tens_d;
      hold_q <= hold_d;
      bon_q  <= bon_d;
      tc_q   <= tc_d;
      bc_q   <= bc_d;
      seg_q  <= seg_d;
    end
  end

endmodule
